FILE: sv/cclin_pkg.sv
package cclin_pkg;

    localparam int IN_TDATA_W  = 288;
    localparam int OUT_TDATA_W = 312;
    localparam int OUT_TUSER_W = 1;
    localparam int SQRT_LAT    = 32;
    localparam int DIV_LAT     = 48;
    localparam int QUEUE_DEPTH = 4;

    typedef logic signed [31:0] t_q;
    typedef logic [15:0]        t_weight;

    typedef enum logic [1:0] {
        CFG_CONTOUR  = 2'd0,
        CFG_LAG      = 2'd1,
        CFG_PROGRESS = 2'd2
    } t_cfg_idx;

    localparam t_weight WEIGHT_ONE = 16'd256;

    localparam logic signed [63:0] QMAX64 = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] QMIN64 = -64'sh0000_0000_8000_0000;

    typedef struct packed {
        t_weight cw;
        t_weight lw;
        t_weight pw;
    } t_weights;

    typedef struct packed {
        logic deg;
        t_q   px;
        t_q   py;
        t_q   ps;
        t_q   dx;
        t_q   dy;
        t_q   ddx;
        t_q   ddy;
        t_q   ex;
        t_q   ey;
    } t_job;

    typedef struct packed {
        logic        vld;
        logic        deg;
        t_q          px;
        t_q          py;
        t_q          ps;
        t_q          dx;
        t_q          dy;
        t_q          ex;
        t_q          ey;
        t_q          num;
        logic [30:0] n;
        t_q          sn;
        t_q          cs;
        t_q          k;
    } t_ctx;

    typedef struct packed {
        logic        deg;
        logic [16:0] speed;
        t_q          lin_s;
        t_q          lin_y;
        t_q          lin_x;
        t_q          quad_ss;
        t_q          quad_ys;
        t_q          quad_yy;
        t_q          quad_xs;
        t_q          quad_xy;
        t_q          quad_xx;
    } t_res;

    function automatic logic signed [63:0] ext64(input t_q x);
        return {{32{x[31]}}, x};
    endfunction

    function automatic t_q sat64(input logic signed [63:0] x);
        if (x > QMAX64) begin
            return 32'sh7FFF_FFFF;
        end else if (x < QMIN64) begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

    // Q16.16 product, floor rounding
    function automatic t_q fmul(input t_q a, input t_q b);
        logic signed [63:0] p;
        p = a * b;
        return sat64(p >>> 16);
    endfunction

    // Q16.16 times unsigned Q8.8 weight
    function automatic t_q wmul(input t_q a, input t_weight w);
        logic signed [48:0] p;
        logic signed [48:0] s;
        p = a * $signed({1'b0, w});
        s = p >>> 8;
        return sat64({{15{s[48]}}, s});
    endfunction

endpackage

FILE: sv/cclin_front.sv
module cclin_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_tvalid,
    output logic                           o_tready,
    input  logic [cclin_pkg::IN_TDATA_W-1:0] i_tdata,
    output logic                           o_valid,
    input  logic                           i_ready,
    output cclin_pkg::t_job                o_job
);
    import cclin_pkg::*;

    logic r_v;
    t_job r_job;
    t_job n_job;
    t_q   rx;
    t_q   ry;

    assign o_tready = !r_v || i_ready;
    assign o_valid  = r_v;
    assign o_job    = r_job;

    always_comb begin
        n_job.px  = t_q'(i_tdata[31:0]);
        n_job.py  = t_q'(i_tdata[63:32]);
        n_job.ps  = t_q'(i_tdata[95:64]);
        rx        = t_q'(i_tdata[127:96]);
        ry        = t_q'(i_tdata[159:128]);
        n_job.dx  = t_q'(i_tdata[191:160]);
        n_job.dy  = t_q'(i_tdata[223:192]);
        n_job.ddx = t_q'(i_tdata[255:224]);
        n_job.ddy = t_q'(i_tdata[287:256]);
        n_job.deg = (n_job.dx == '0) && (n_job.dy == '0);
        n_job.ex  = sat64(ext64(n_job.px) - ext64(rx));
        n_job.ey  = sat64(ext64(n_job.py) - ext64(ry));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_tready) begin
            r_v <= i_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_tready && i_tvalid) begin
            r_job <= n_job;
        end
    end

endmodule

FILE: sv/cclin_queue.sv
module cclin_queue #(
    parameter int DEPTH = cclin_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  cclin_pkg::t_job i_job,
    output logic            o_valid,
    input  logic            i_pop,
    output cclin_pkg::t_job o_job
);
    import cclin_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_job            r_mem [DEPTH];
    logic [AW-1:0]   r_wp;
    logic [AW-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;
    logic            push;

    function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_ready = r_cnt != CW'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_job   = r_mem[r_rp];
    assign push    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= nxt(r_wp);
            end
            if (i_pop) begin
                r_rp <= nxt(r_rp);
            end
            case ({push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

FILE: sv/cclin_sqrt.sv
module cclin_sqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_v,
    output logic [31:0] o_r
);
    import cclin_pkg::*;

    logic [63:0] r_v [SQRT_LAT];
    logic [63:0] r_r [SQRT_LAT];

    for (genvar g = 0; g < SQRT_LAT; g++) begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * g);
        logic [63:0] v_i;
        logic [63:0] r_i;
        logic [63:0] sum;
        logic        ge;

        if (g == 0) begin : g_first
            assign v_i = i_v;
            assign r_i = '0;
        end else begin : g_rest
            assign v_i = r_v[g-1];
            assign r_i = r_r[g-1];
        end

        assign sum = r_i + BIT;
        assign ge  = v_i >= sum;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[g] <= ge ? v_i - sum : v_i;
                r_r[g] <= ge ? (r_i >> 1) + BIT : r_i >> 1;
            end
        end
    end

    assign o_r = r_r[SQRT_LAT-1][31:0];

endmodule

FILE: sv/cclin_div.sv
module cclin_div (
    input  logic            i_clk,
    input  logic            i_en,
    input  cclin_pkg::t_q   i_a,
    input  logic [30:0]     i_n,
    output cclin_pkg::t_q   o_q
);
    import cclin_pkg::*;

    // (|a| << 16) / n, one quotient bit per stage
    logic [47:0] r_d   [DIV_LAT];
    logic [30:0] r_rem [DIV_LAT];
    logic [30:0] r_n   [DIV_LAT];
    logic        r_neg [DIV_LAT];
    logic [31:0] mag;
    logic [47:0] q;

    assign mag = i_a[31] ? ~i_a + 32'd1 : i_a;

    for (genvar g = 0; g < DIV_LAT; g++) begin : g_stage
        logic [47:0] d_i;
        logic [30:0] rem_i;
        logic [30:0] n_i;
        logic        neg_i;
        logic [31:0] t;
        logic [31:0] diff;
        logic        ge;

        if (g == 0) begin : g_first
            assign d_i   = {mag, 16'd0};
            assign rem_i = '0;
            assign n_i   = i_n;
            assign neg_i = i_a[31];
        end else begin : g_rest
            assign d_i   = r_d[g-1];
            assign rem_i = r_rem[g-1];
            assign n_i   = r_n[g-1];
            assign neg_i = r_neg[g-1];
        end

        assign t    = {rem_i, d_i[47]};
        assign diff = t - {1'b0, n_i};
        assign ge   = t >= {1'b0, n_i};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d[g]   <= {d_i[46:0], ge};
                r_rem[g] <= ge ? diff[30:0] : t[30:0];
                r_n[g]   <= n_i;
                r_neg[g] <= neg_i;
            end
        end
    end

    assign q = r_d[DIV_LAT-1];

    always_comb begin
        if (!r_neg[DIV_LAT-1]) begin
            o_q = (q > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : t_q'(q[31:0]);
        end else begin
            o_q = (q > 48'h0000_8000_0000) ? 32'sh8000_0000 : t_q'(~q[31:0] + 32'd1);
        end
    end

endmodule

FILE: sv/cclin_back.sv
module cclin_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  cclin_pkg::t_job     i_q_job,
    output logic                o_q_pop,
    input  cclin_pkg::t_weights i_w,
    output logic                o_valid,
    input  logic                i_ready,
    output cclin_pkg::t_res     o_res
);
    import cclin_pkg::*;

    logic en;

    logic               r_s0_v;
    t_job               r_s0_job;
    logic signed [63:0] r_pxx, r_pyy, r_pa, r_pb;

    t_ctx        r_s1_ctx;
    t_ctx        n_s1_ctx;
    logic [63:0] r_s1_ss;

    t_ctx r_c1 [SQRT_LAT];
    t_ctx r_c2 [DIV_LAT];
    t_ctx r_c3 [DIV_LAT];
    t_ctx r_c4 [DIV_LAT];
    t_ctx ctx_n, ctx_d1, ctx_d2, ctx_d3;

    logic [31:0] sq_r;
    t_q          q_sn, q_cs, q_k1, q_k2, q_k3;

    logic r_a1_v, r_a2_v, r_a3_v, r_a4_v, r_a5_v, r_a6_v, r_a7_v, r_ov;
    logic r_a1_deg, r_a2_deg, r_a3_deg, r_a4_deg, r_a5_deg, r_a6_deg, r_a7_deg;

    t_q r_a1_px, r_a1_py, r_a1_ps, r_a1_sn, r_a1_cs, r_a1_kap;
    t_q r_m_cex, r_m_sey, r_m_sex, r_m_cey, r_m_dxs, r_m_dyc, r_m_dxc, r_m_dys;

    t_q r_a2_px, r_a2_py, r_a2_ps, r_a2_sn, r_a2_cs, r_a2_ec, r_a2_el;
    t_q r_k_cex, r_k_sey, r_k_sex, r_k_cey;
    t_q r_a2_dxs, r_a2_dyc, r_a2_dxc, r_a2_dys;

    t_q r_a3_px, r_a3_py, r_a3_ps, r_a3_ec, r_a3_el;
    t_q r_a3_j0 [3];
    t_q r_a3_j1 [3];

    t_q r_a4_ec, r_a4_el;
    t_q r_a4_j0 [3];
    t_q r_a4_j1 [3];
    t_q r_t0 [3];
    t_q r_t1 [3];
    t_q r_qp0 [6];
    t_q r_qp1 [6];

    t_q r_a5_eb0, r_a5_eb1;
    t_q r_a5_j0 [3];
    t_q r_a5_j1 [3];
    t_q r_w0 [6];
    t_q r_w1 [6];

    t_q r_a6_quad [6];
    t_q r_f0 [3];
    t_q r_f1 [3];

    t_q r_a7_quad [6];
    t_q r_g0 [3];
    t_q r_g1 [3];

    t_res r_res;
    t_q   dc, dl, ncs, nsn;
    t_q   lin [3];

    assign en      = !r_ov || i_ready;
    assign o_q_pop = en && i_q_valid;
    assign o_valid = r_ov;
    assign o_res   = r_res;

    // products and squared tangent length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (en) begin
            r_s0_v <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_job <= i_q_job;
            r_pxx    <= i_q_job.dx * i_q_job.dx;
            r_pyy    <= i_q_job.dy * i_q_job.dy;
            r_pa     <= i_q_job.dx * i_q_job.ddy;
            r_pb     <= i_q_job.dy * i_q_job.ddx;
        end
    end

    always_comb begin
        n_s1_ctx     = '0;
        n_s1_ctx.vld = r_s0_v;
        n_s1_ctx.deg = r_s0_job.deg;
        n_s1_ctx.px  = r_s0_job.px;
        n_s1_ctx.py  = r_s0_job.py;
        n_s1_ctx.ps  = r_s0_job.ps;
        n_s1_ctx.dx  = r_s0_job.dx;
        n_s1_ctx.dy  = r_s0_job.dy;
        n_s1_ctx.ex  = r_s0_job.ex;
        n_s1_ctx.ey  = r_s0_job.ey;
        n_s1_ctx.num = sat64((r_pa >>> 16) - (r_pb >>> 16));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctx <= '0;
        end else if (en) begin
            r_s1_ctx <= n_s1_ctx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_ss <= 64'(r_pxx) + 64'(r_pyy);
        end
    end

    // square root
    cclin_sqrt u_sqrt (
        .i_clk (i_clk),
        .i_en  (en),
        .i_v   (r_s1_ss),
        .o_r   (sq_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SQRT_LAT; i++) r_c1[i] <= '0;
        end else if (en) begin
            r_c1[0] <= r_s1_ctx;
            for (int i = 1; i < SQRT_LAT; i++) r_c1[i] <= r_c1[i-1];
        end
    end

    always_comb begin
        ctx_n = r_c1[SQRT_LAT-1];
        if (sq_r[31]) begin
            ctx_n.n = 31'h7FFF_FFFF;
        end else if (sq_r[30:0] == '0) begin
            ctx_n.n = 31'd1;
        end else begin
            ctx_n.n = sq_r[30:0];
        end
    end

    // heading and first curvature divide
    cclin_div u_div_sn (.i_clk(i_clk), .i_en(en), .i_a(ctx_n.dy),  .i_n(ctx_n.n), .o_q(q_sn));
    cclin_div u_div_cs (.i_clk(i_clk), .i_en(en), .i_a(ctx_n.dx),  .i_n(ctx_n.n), .o_q(q_cs));
    cclin_div u_div_k1 (.i_clk(i_clk), .i_en(en), .i_a(ctx_n.num), .i_n(ctx_n.n), .o_q(q_k1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_LAT; i++) r_c2[i] <= '0;
        end else if (en) begin
            r_c2[0] <= ctx_n;
            for (int i = 1; i < DIV_LAT; i++) r_c2[i] <= r_c2[i-1];
        end
    end

    always_comb begin
        ctx_d1    = r_c2[DIV_LAT-1];
        ctx_d1.sn = q_sn;
        ctx_d1.cs = q_cs;
        ctx_d1.k  = q_k1;
    end

    cclin_div u_div_k2 (.i_clk(i_clk), .i_en(en), .i_a(ctx_d1.k), .i_n(ctx_d1.n), .o_q(q_k2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_LAT; i++) r_c3[i] <= '0;
        end else if (en) begin
            r_c3[0] <= ctx_d1;
            for (int i = 1; i < DIV_LAT; i++) r_c3[i] <= r_c3[i-1];
        end
    end

    always_comb begin
        ctx_d2   = r_c3[DIV_LAT-1];
        ctx_d2.k = q_k2;
    end

    cclin_div u_div_k3 (.i_clk(i_clk), .i_en(en), .i_a(ctx_d2.k), .i_n(ctx_d2.n), .o_q(q_k3));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_LAT; i++) r_c4[i] <= '0;
        end else if (en) begin
            r_c4[0] <= ctx_d2;
            for (int i = 1; i < DIV_LAT; i++) r_c4[i] <= r_c4[i-1];
        end
    end

    always_comb begin
        ctx_d3   = r_c4[DIV_LAT-1];
        ctx_d3.k = q_k3;
    end

    // error terms, Jacobian, weighted cost terms and result register (cost terms zeroed when degenerate)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a1_v <= 1'b0;
            r_a2_v <= 1'b0;
            r_a3_v <= 1'b0;
            r_a4_v <= 1'b0;
            r_a5_v <= 1'b0;
            r_a6_v <= 1'b0;
            r_a7_v <= 1'b0;
            r_ov   <= 1'b0;
        end else if (en) begin
            r_a1_v <= ctx_d3.vld;
            r_a2_v <= r_a1_v;
            r_a3_v <= r_a2_v;
            r_a4_v <= r_a3_v;
            r_a5_v <= r_a4_v;
            r_a6_v <= r_a5_v;
            r_a7_v <= r_a6_v;
            r_ov   <= r_a7_v;
        end
    end

    always_comb begin
        dc  = sat64(ext64(r_k_cex) - ext64(r_a2_dxs) + ext64(r_k_sey) + ext64(r_a2_dyc));
        dl  = sat64(ext64(r_k_sex) + ext64(r_a2_dxc) - ext64(r_k_cey) + ext64(r_a2_dys));
        ncs = sat64(-ext64(r_a2_cs));
        nsn = sat64(-ext64(r_a2_sn));
        for (int i = 0; i < 3; i++) begin
            lin[i] = sat64((ext64(r_g0[i]) + ext64(r_g1[i])) <<< 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a1_deg <= ctx_d3.deg;
            r_a1_px  <= ctx_d3.px;
            r_a1_py  <= ctx_d3.py;
            r_a1_ps  <= ctx_d3.ps;
            r_a1_sn  <= ctx_d3.sn;
            r_a1_cs  <= ctx_d3.cs;
            r_a1_kap <= ctx_d3.k;
            r_m_cex  <= fmul(ctx_d3.cs, ctx_d3.ex);
            r_m_sey  <= fmul(ctx_d3.sn, ctx_d3.ey);
            r_m_sex  <= fmul(ctx_d3.sn, ctx_d3.ex);
            r_m_cey  <= fmul(ctx_d3.cs, ctx_d3.ey);
            r_m_dxs  <= fmul(ctx_d3.dx, ctx_d3.sn);
            r_m_dyc  <= fmul(ctx_d3.dy, ctx_d3.cs);
            r_m_dxc  <= fmul(ctx_d3.dx, ctx_d3.cs);
            r_m_dys  <= fmul(ctx_d3.dy, ctx_d3.sn);

            r_a2_deg <= r_a1_deg;
            r_a2_px  <= r_a1_px;
            r_a2_py  <= r_a1_py;
            r_a2_ps  <= r_a1_ps;
            r_a2_sn  <= r_a1_sn;
            r_a2_cs  <= r_a1_cs;
            r_a2_ec  <= sat64(ext64(r_m_sex) - ext64(r_m_cey));
            r_a2_el  <= sat64(-ext64(r_m_cex) - ext64(r_m_sey));
            r_k_cex  <= fmul(r_a1_kap, r_m_cex);
            r_k_sey  <= fmul(r_a1_kap, r_m_sey);
            r_k_sex  <= fmul(r_a1_kap, r_m_sex);
            r_k_cey  <= fmul(r_a1_kap, r_m_cey);
            r_a2_dxs <= r_m_dxs;
            r_a2_dyc <= r_m_dyc;
            r_a2_dxc <= r_m_dxc;
            r_a2_dys <= r_m_dys;

            r_a3_deg   <= r_a2_deg;
            r_a3_px    <= r_a2_px;
            r_a3_py    <= r_a2_py;
            r_a3_ps    <= r_a2_ps;
            r_a3_ec    <= r_a2_ec;
            r_a3_el    <= r_a2_el;
            r_a3_j0[0] <= r_a2_sn;
            r_a3_j0[1] <= ncs;
            r_a3_j0[2] <= dc;
            r_a3_j1[0] <= ncs;
            r_a3_j1[1] <= nsn;
            r_a3_j1[2] <= dl;

            r_a4_deg <= r_a3_deg;
            r_a4_ec  <= r_a3_ec;
            r_a4_el  <= r_a3_el;
            r_a4_j0  <= r_a3_j0;
            r_a4_j1  <= r_a3_j1;
            r_t0[0]  <= fmul(r_a3_j0[0], r_a3_px);
            r_t0[1]  <= fmul(r_a3_j0[1], r_a3_py);
            r_t0[2]  <= fmul(r_a3_j0[2], r_a3_ps);
            r_t1[0]  <= fmul(r_a3_j1[0], r_a3_px);
            r_t1[1]  <= fmul(r_a3_j1[1], r_a3_py);
            r_t1[2]  <= fmul(r_a3_j1[2], r_a3_ps);
            r_qp0[0] <= fmul(r_a3_j0[0], r_a3_j0[0]);
            r_qp0[1] <= fmul(r_a3_j0[0], r_a3_j0[1]);
            r_qp0[2] <= fmul(r_a3_j0[0], r_a3_j0[2]);
            r_qp0[3] <= fmul(r_a3_j0[1], r_a3_j0[1]);
            r_qp0[4] <= fmul(r_a3_j0[1], r_a3_j0[2]);
            r_qp0[5] <= fmul(r_a3_j0[2], r_a3_j0[2]);
            r_qp1[0] <= fmul(r_a3_j1[0], r_a3_j1[0]);
            r_qp1[1] <= fmul(r_a3_j1[0], r_a3_j1[1]);
            r_qp1[2] <= fmul(r_a3_j1[0], r_a3_j1[2]);
            r_qp1[3] <= fmul(r_a3_j1[1], r_a3_j1[1]);
            r_qp1[4] <= fmul(r_a3_j1[1], r_a3_j1[2]);
            r_qp1[5] <= fmul(r_a3_j1[2], r_a3_j1[2]);

            r_a5_deg <= r_a4_deg;
            r_a5_j0  <= r_a4_j0;
            r_a5_j1  <= r_a4_j1;
            r_a5_eb0 <= sat64(ext64(r_a4_ec)
                        - (ext64(r_t0[0]) + ext64(r_t0[1]) + ext64(r_t0[2])));
            r_a5_eb1 <= sat64(ext64(r_a4_el)
                        - (ext64(r_t1[0]) + ext64(r_t1[1]) + ext64(r_t1[2])));
            for (int k = 0; k < 6; k++) begin
                r_w0[k] <= wmul(r_qp0[k], i_w.cw);
                r_w1[k] <= wmul(r_qp1[k], i_w.lw);
            end

            r_a6_deg <= r_a5_deg;
            for (int k = 0; k < 6; k++) begin
                r_a6_quad[k] <= sat64(ext64(r_w0[k]) + ext64(r_w1[k]));
            end
            for (int i = 0; i < 3; i++) begin
                r_f0[i] <= fmul(r_a5_eb0, r_a5_j0[i]);
                r_f1[i] <= fmul(r_a5_eb1, r_a5_j1[i]);
            end

            r_a7_deg  <= r_a6_deg;
            r_a7_quad <= r_a6_quad;
            for (int i = 0; i < 3; i++) begin
                r_g0[i] <= wmul(r_f0[i], i_w.cw);
                r_g1[i] <= wmul(r_f1[i], i_w.lw);
            end

            r_res.deg   <= r_a7_deg;
            r_res.speed <= 17'd0 - {1'b0, i_w.pw};
            if (r_a7_deg) begin
                r_res.quad_xx <= '0;
                r_res.quad_xy <= '0;
                r_res.quad_xs <= '0;
                r_res.quad_yy <= '0;
                r_res.quad_ys <= '0;
                r_res.quad_ss <= '0;
                r_res.lin_x   <= '0;
                r_res.lin_y   <= '0;
                r_res.lin_s   <= '0;
            end else begin
                r_res.quad_xx <= r_a7_quad[0];
                r_res.quad_xy <= r_a7_quad[1];
                r_res.quad_xs <= r_a7_quad[2];
                r_res.quad_yy <= r_a7_quad[3];
                r_res.quad_ys <= r_a7_quad[4];
                r_res.quad_ss <= r_a7_quad[5];
                r_res.lin_x   <= lin[0];
                r_res.lin_y   <= lin[1];
                r_res.lin_s   <= lin[2];
            end
        end
    end

endmodule

FILE: sv/contouring_cost_linearizer.sv
// Path from request accept to result valid: front register, queue, product stages, the
//   32-stage square root, three chained 48-stage dividers, then the arithmetic stages.
// Throughput: one request per cycle; the back pipeline advances whenever the
//   output register is empty or being taken.
// Reset: synchronous, active low; clears all valid state, weights return to 1.0.
module contouring_cost_linearizer #(
    parameter int QDEPTH = cclin_pkg::QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // pos_x, pos_y, progress, ref_x, ref_y, tan_x, tan_y, bend_x, bend_y
    input  logic [cclin_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // quad_xx, quad_xy, quad_xs, quad_yy, quad_ys, quad_ss, lin_x, lin_y,
    // lin_s, speed_quad, zero pad
    output logic [cclin_pkg::OUT_TDATA_W-1:0] m_tdata,
    // degenerate
    output logic [cclin_pkg::OUT_TUSER_W-1:0] m_tuser,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [1:0]                        i_cfg_index,
    input  logic [15:0]                       i_cfg_data
);
    import cclin_pkg::*;

    t_weights r_w;
    logic     f_valid, f_ready;
    t_job     f_job;
    logic     q_valid, q_pop;
    t_job     q_job;
    t_res     res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w.cw <= WEIGHT_ONE;
            r_w.lw <= WEIGHT_ONE;
            r_w.pw <= WEIGHT_ONE;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CONTOUR:  r_w.cw <= i_cfg_data;
                CFG_LAG:      r_w.lw <= i_cfg_data;
                CFG_PROGRESS: r_w.pw <= i_cfg_data;
                default:      r_w    <= r_w;
            endcase
        end
    end

    cclin_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_tvalid),
        .o_tready (s_tready),
        .i_tdata  (s_tdata),
        .o_valid  (f_valid),
        .i_ready  (f_ready),
        .o_job    (f_job)
    );

    cclin_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_job   (f_job),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_job   (q_job)
    );

    cclin_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_job   (q_job),
        .o_q_pop   (q_pop),
        .i_w       (r_w),
        .o_valid   (m_tvalid),
        .i_ready   (m_tready),
        .o_res     (res)
    );

    assign m_tdata = {7'd0, res.speed, res.lin_s, res.lin_y, res.lin_x,
                      res.quad_ss, res.quad_ys, res.quad_yy, res.quad_xs,
                      res.quad_xy, res.quad_xx};
    assign m_tuser = res.deg;

endmodule

FILE: sv/cclin_chk.sv
module cclin_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [cclin_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic [cclin_pkg::OUT_TUSER_W-1:0] m_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[287:0] == '0)
        else $error("degenerate result with nonzero cost terms");

    a_speed_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[304] || m_tdata[304:288] == '0) && m_tdata[311:305] == '0)
        else $error("speed term positive or padding set");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind contouring_cost_linearizer cclin_chk u_chk (.*);
